FILE: src/tpsi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the padded-tensor source index pipeline.
// No dependencies; used by the interfaces, the remainder lane and the core.
package tpsi_pkg;

   // Rank handling: fields are always four wide, only the inner dims are active
   localparam int DIMS        = 4;
   localparam int NUM_FIELDS  = 4;
   localparam int ACTIVE_DIMS = (DIMS > NUM_FIELDS) ? NUM_FIELDS : ((DIMS < 1) ? 1 : DIMS);
   localparam int FIRST_DIM   = NUM_FIELDS - ACTIVE_DIMS;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 2;   // coord - signed pad
   localparam int ABS_W   = COORD_W + 1;   // magnitude of that difference
   localparam int IDX_W   = 64;
   localparam int FILL_W  = 32;
   localparam int CFG_W   = 64;
   localparam int CSR_IDX_W = 2;

   // remainder unit resolves one quotient bit per stage
   localparam int DIV_STAGES = ABS_W;

   typedef enum logic [1:0] {
      MODE_CONST   = 2'd0,
      MODE_REFLECT = 2'd1,
      MODE_EDGE    = 2'd2,
      MODE_WRAP    = 2'd3
   } border_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHAPE = 2'd0,
      CSR_PADS  = 2'd1,
      CSR_MODE  = 2'd2,
      CSR_FILL  = 2'd3
   } csr_index_type;

   // per-lane side flags riding along with the remainder
   typedef struct packed {
      logic neg;       // shifted coordinate below zero
      logic outside;   // shifted coordinate outside [0, len)
   } lane_flags_type;

endpackage

FILE: src/tpsi_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for coordinate requests and index responses.
// Depends on tpsi_pkg for field widths.
interface tpsi_req_if import tpsi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_coord_0;
   logic [COORD_W-1:0] out_coord_1;
   logic [COORD_W-1:0] out_coord_2;
   logic [COORD_W-1:0] out_coord_3;

   modport source (output valid, out_coord_0, out_coord_1, out_coord_2, out_coord_3,
                   input ready);
   modport sink (input valid, out_coord_0, out_coord_1, out_coord_2, out_coord_3,
                 output ready);
endinterface

interface tpsi_rsp_if import tpsi_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              is_padding;
   logic [IDX_W-1:0]  source_index;
   logic [FILL_W-1:0] fill_word;

   modport source (output valid, is_padding, source_index, fill_word, input ready);
   modport sink (input valid, is_padding, source_index, fill_word, output ready);
endinterface

FILE: src/tpsi_rem.sv
`timescale 1ns / 1ps
// One lane of the pipelined restoring remainder: abs_in mod modulus.
// Depends on tpsi_pkg; modulus is static configuration during operation.
module tpsi_rem import tpsi_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [ABS_W-1:0]     abs_in,
   input  lane_flags_type       flags_in,
   input  logic [ABS_W-1:0]     modulus,
   output logic [ABS_W-1:0]     rem_out,
   output lane_flags_type       flags_out
);

   logic [ABS_W-1:0]  rem_ff   [DIV_STAGES];
   lane_flags_type    flags_ff [DIV_STAGES];

   // stage j tries to subtract modulus << (DIV_STAGES-1-j)
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      logic [ABS_W-1:0]   src;
      lane_flags_type     src_flags;
      logic [2*ABS_W-1:0] divisor;
      logic [ABS_W-1:0]   rem_in;

      if (j == 0) begin : g_first
         assign src       = abs_in;
         assign src_flags = flags_in;
      end else begin : g_next
         assign src       = rem_ff[j-1];
         assign src_flags = flags_ff[j-1];
      end

      always_comb begin
         divisor = {{ABS_W{1'b0}}, modulus} << (DIV_STAGES - 1 - j);
         if ({{ABS_W{1'b0}}, src} >= divisor) begin
            rem_in = src - divisor[ABS_W-1:0];
         end else begin
            rem_in = src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j]   <= rem_in;
            flags_ff[j] <= src_flags;
         end
      end
   end

   assign rem_out   = rem_ff[DIV_STAGES-1];
   assign flags_out = flags_ff[DIV_STAGES-1];

endmodule

FILE: src/tensor_pad_source_index_core.sv
`timescale 1ns / 1ps
// Top level: maps an output coordinate of a padded 4-D tensor to its source index.
// Depends on tpsi_pkg, tpsi_ifs (channel interfaces) and tpsi_rem (remainder lanes).
//
//   channel   dir  beat contents
//   req_chan  in   out_coord_0..out_coord_3
//   rsp_chan  out  is_padding, source_index, fill_word
//   csr_*     in   write enable, register index, 64-bit data
//
// One beat enters per cycle while the response is not stalled; 24 register stages
// (offset, 17 remainder stages, positive remainder, fold, three multiply-accumulate
// stages, output) lie between the request beat and the response.
// The whole pipeline advances together when the output register is empty or
// taken; a stalled response freezes every stage, nothing is dropped.
// Synchronous active-high reset clears valid bits and configuration.
module tensor_pad_source_index_core import tpsi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tpsi_req_if.sink             req_chan,
   tpsi_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   localparam int ST_A    = DIV_STAGES + 1;
   localparam int ST_B    = ST_A + 1;
   localparam int ST_OUT  = ST_B + 4;
   localparam int PIPE_LEN = ST_OUT + 1;

   // configuration registers
   logic [CFG_W-1:0]  shape_ff;
   logic [CFG_W-1:0]  pads_ff;
   border_mode_type   mode_ff;
   logic [FILL_W-1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= '0;
         pads_ff  <= '0;
         mode_ff  <= MODE_CONST;
         fill_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SHAPE: shape_ff <= csr_write_data;
            CSR_PADS:  pads_ff  <= csr_write_data;
            CSR_MODE:  mode_ff  <= border_mode_type'(csr_write_data[1:0]);
            CSR_FILL:  fill_ff  <= csr_write_data[FILL_W-1:0];
            default:   ;
         endcase
      end
   end

   // static per-dim lengths, pads and moduli
   logic [COORD_W-1:0] len      [NUM_FIELDS];
   logic [COORD_W-1:0] eff_len  [NUM_FIELDS];
   logic [COORD_W-1:0] pad_amt  [NUM_FIELDS];
   logic [ABS_W-1:0]   modulus  [NUM_FIELDS];

   always_comb begin
      for (int d = 0; d < NUM_FIELDS; d++) begin
         len[d]     = shape_ff[(NUM_FIELDS-1-d)*COORD_W +: COORD_W];
         pad_amt[d] = pads_ff[(NUM_FIELDS-1-d)*COORD_W +: COORD_W];
         eff_len[d] = (d < FIRST_DIM) ? COORD_W'(1) : len[d];
         if (mode_ff == MODE_REFLECT) begin
            modulus[d] = {len[d], 1'b0} - ABS_W'(2);
         end else begin
            modulus[d] = {1'b0, len[d]};
         end
      end
   end

   // pipeline control: one advance for all stages
   logic [PIPE_LEN-1:0] vld_ff;
   logic                advance;

   assign advance        = !vld_ff[PIPE_LEN-1] || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], req_chan.valid};
      end
   end

   // stage 0: subtract begin pad, split into sign and magnitude
   logic [COORD_W-1:0] coord_in [NUM_FIELDS];
   logic [ABS_W-1:0]   abs_ff   [NUM_FIELDS];
   lane_flags_type     flags_ff [NUM_FIELDS];
   logic [ABS_W-1:0]   abs_in   [NUM_FIELDS];
   lane_flags_type     flags_in [NUM_FIELDS];

   assign coord_in[0] = req_chan.out_coord_0;
   assign coord_in[1] = req_chan.out_coord_1;
   assign coord_in[2] = req_chan.out_coord_2;
   assign coord_in[3] = req_chan.out_coord_3;

   always_comb begin
      logic [DIFF_W-1:0] diff;
      for (int d = 0; d < NUM_FIELDS; d++) begin
         diff = {2'b00, coord_in[d]} - {{2{pad_amt[d][COORD_W-1]}}, pad_amt[d]};
         flags_in[d].neg = diff[DIFF_W-1];
         if (diff[DIFF_W-1]) begin
            abs_in[d] = ABS_W'(-diff);
         end else begin
            abs_in[d] = diff[ABS_W-1:0];
         end
         flags_in[d].outside = diff[DIFF_W-1] || (diff[ABS_W-1:0] >= {1'b0, len[d]});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_ff   <= abs_in;
         flags_ff <= flags_in;
      end
   end

   // remainder lanes
   logic [ABS_W-1:0] rem      [NUM_FIELDS];
   lane_flags_type   rem_flags[NUM_FIELDS];

   for (genvar d = 0; d < NUM_FIELDS; d++) begin : g_lane
      tpsi_rem u_rem (
         .clock     (clock),
         .enable    (advance),
         .abs_in    (abs_ff[d]),
         .flags_in  (flags_ff[d]),
         .modulus   (modulus[d]),
         .rem_out   (rem[d]),
         .flags_out (rem_flags[d])
      );
   end

   // stage A: positive remainder for negative coordinates
   logic [ABS_W-1:0] k_ff       [NUM_FIELDS];
   lane_flags_type   k_flags_ff [NUM_FIELDS];
   logic [ABS_W-1:0] k_in       [NUM_FIELDS];

   always_comb begin
      for (int d = 0; d < NUM_FIELDS; d++) begin
         if (rem_flags[d].neg && (rem[d] != '0)) begin
            k_in[d] = modulus[d] - rem[d];
         end else begin
            k_in[d] = rem[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k_ff       <= k_in;
         k_flags_ff <= rem_flags;
      end
   end

   // stage B: apply border mode, produce source coordinate per dim
   logic [COORD_W-1:0] src_ff [NUM_FIELDS];
   logic [COORD_W-1:0] src_in [NUM_FIELDS];
   logic               padb_ff;
   logic               padb_in;

   always_comb begin
      logic [ABS_W-1:0] folded;
      padb_in = 1'b0;
      for (int d = 0; d < NUM_FIELDS; d++) begin
         src_in[d] = '0;
         folded    = k_ff[d];
         if (folded >= {1'b0, len[d]}) begin
            folded = modulus[d] - folded;
         end
         if (d >= FIRST_DIM) begin
            if (len[d] == '0) begin
               padb_in = 1'b1;
            end else if (!k_flags_ff[d].outside) begin
               src_in[d] = k_ff[d][COORD_W-1:0];
            end else begin
               case (mode_ff)
                  MODE_CONST: padb_in = 1'b1;
                  MODE_EDGE: src_in[d] = k_flags_ff[d].neg ? '0 : len[d] - COORD_W'(1);
                  MODE_REFLECT: begin
                     if (len[d] == COORD_W'(1)) begin
                        src_in[d] = '0;
                     end else begin
                        src_in[d] = folded[COORD_W-1:0];
                     end
                  end
                  MODE_WRAP: src_in[d] = k_ff[d][COORD_W-1:0];
                  default: padb_in = 1'b1;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         src_ff  <= src_in;
         padb_ff <= padb_in;
      end
   end

   // row-major accumulate, one multiply per stage
   logic [2*COORD_W:0]   acc1_ff;
   logic [3*COORD_W+1:0] acc2_ff;
   logic [IDX_W-1:0]     acc3_ff;
   logic [COORD_W-1:0]   c2_ff, c3_ff, c3b_ff;
   logic                 pad1_ff, pad2_ff, pad3_ff;
   logic [IDX_W+1:0]     prod3;

   assign prod3 = {16'b0, acc2_ff} * {50'b0, eff_len[3]};

   always_ff @(posedge clock) begin
      if (advance) begin
         acc1_ff <= ({17'b0, src_ff[0]} * {17'b0, eff_len[1]}) + (2*COORD_W+1)'(src_ff[1]);
         c2_ff   <= src_ff[2];
         c3_ff   <= src_ff[3];
         pad1_ff <= padb_ff;

         acc2_ff <= ({17'b0, acc1_ff} * {34'b0, eff_len[2]}) + (3*COORD_W+2)'(c2_ff);
         c3b_ff  <= c3_ff;
         pad2_ff <= pad1_ff;

         acc3_ff <= prod3[IDX_W-1:0] + IDX_W'(c3b_ff);
         pad3_ff <= pad2_ff;
      end
   end

   // output register
   logic              opad_ff;
   logic [IDX_W-1:0]  oidx_ff;
   logic [FILL_W-1:0] ofill_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         opad_ff  <= pad3_ff;
         oidx_ff  <= pad3_ff ? '0 : acc3_ff;
         ofill_ff <= pad3_ff ? fill_ff : '0;
      end
   end

   assign rsp_chan.valid        = vld_ff[PIPE_LEN-1];
   assign rsp_chan.is_padding   = opad_ff;
   assign rsp_chan.source_index = oidx_ff;
   assign rsp_chan.fill_word    = ofill_ff;

endmodule
